// ===== rtl/core/rlvo_pkg.sv =====
// ----------------------------------------------------------------------------
// rlvo_pkg: shared types and constants for the three-voice oscillator
// Holds the sequencer states, register indexes, shape and stage codes and the
// fixed arithmetic constants of the glide, saw, sine, square and volume paths.
// ----------------------------------------------------------------------------
package rlvo_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GLIDE_MUL,
        S_GLIDE_SUM,
        S_DIV_PREP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_V_ADV,
        S_V_LOOK,
        S_V_SHAPE,
        S_V_SCALE,
        S_OUT
    } seq_state_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_VOLUME      = 3'd0;
    localparam logic [2:0] REG_TARGET_FREQ = 3'd1;
    localparam logic [2:0] REG_RATIO_NUM_A = 3'd2;
    localparam logic [2:0] REG_RATIO_DEN_A = 3'd3;
    localparam logic [2:0] REG_RATIO_NUM_B = 3'd4;
    localparam logic [2:0] REG_RATIO_DEN_B = 3'd5;
    localparam logic [2:0] REG_WAVE_SHAPES = 3'd6;
    localparam logic [2:0] REG_FREEZE_MASK = 3'd7;

    localparam logic [1:0] SHAPE_SINE   = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE = 2'd1;
    localparam logic [1:0] SHAPE_SAW    = 2'd2;

    localparam logic [1:0] STAGE_BASE  = 2'd0;
    localparam logic [1:0] STAGE_RATIO_A = 2'd1;
    localparam logic [1:0] STAGE_RATIO_B = 2'd2;
    localparam logic [1:0] LAST_VOICE  = 2'd2;

    localparam logic [15:0] GLIDE_KEEP = 16'd64225;
    localparam logic [10:0] GLIDE_TAKE = 11'd1311;
    localparam logic [30:0] PI_Q29     = 31'd1686629713;
    localparam logic [15:0] VOL_MAX    = 16'd32768;
    localparam logic [13:0] ONE_Q13    = 14'd8192;
    localparam logic [31:0] GLIDE_RESET = 32'd7208960;

    // divisor width: covers sample rates below 2^18 and the 8-bit ratio registers
    localparam int DIV_VW = 18;

    localparam real HALF_PI = 1.5707963267948966;

    // round(8192 * sin(i * step)), for the first quarter turn
    function automatic int sine_q13(input int i, input real step);
        real x;
        x = 8192.0 * $sin(i * step);
        return $rtoi(x + 0.5);
    endfunction

endpackage

// ===== rtl/core/rlvo_div.sv =====
// ----------------------------------------------------------------------------
// rlvo_div: restoring divider, one quotient bit per cycle
// Latches dividend and divisor on start, pulses done once the last quotient
// bit is in and holds the quotient until the next start.
// ----------------------------------------------------------------------------
module rlvo_div
    import rlvo_pkg::*;
#(
    parameter int DW = 52,
    parameter int VW = 18
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift one dividend bit in, subtract where it fits
            rem_next = ge ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/rlvo_sine_rom.sv =====
// ----------------------------------------------------------------------------
// rlvo_sine_rom: quarter-wave sine lookup with registered read
// Folds the full-turn index onto a quarter table and restores the sign.
// ----------------------------------------------------------------------------
module rlvo_sine_rom
    import rlvo_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  logic                  aclk,
    input  logic [TABLE_BITS-1:0] addr,
    output logic signed [14:0]    data
);

    localparam int  QW      = TABLE_BITS - 2;
    localparam int  QUARTER = 1 << QW;
    localparam real STEP    = HALF_PI / QUARTER;

    logic [13:0]     qtab [QUARTER+1];
    logic [1:0]      quad;
    logic [QW-1:0]   r;
    logic [QW:0]     idx;
    logic [13:0]     mag;
    logic signed [14:0] data_reg;

    for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
        assign qtab[k] = 14'(sine_q13(k, STEP));
    end

    assign quad = addr[TABLE_BITS-1 -: 2];
    assign r    = addr[QW-1:0];
    assign idx  = quad[0] ? (QW+1)'(QUARTER) - {1'b0, r} : {1'b0, r};
    assign mag  = qtab[idx];

    always_ff @(posedge aclk) begin
        data_reg <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/ratio_locked_three_voice_oscillator_core.sv =====
// ----------------------------------------------------------------------------
// ratio_locked_three_voice_oscillator_core: three ratio-locked DDS voices
// Gliding base frequency, three phase accumulators, sine/square/saw shapes,
// volume scaling and a three-voice mix; voices in Q2.13, the mix in Q4.13.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one sample tick; s_tdata[0] flags the
//   first sample of a block. On such a tick the glide frequency moves 2%
//   toward target_freq and the three phase steps are recomputed; then every
//   unfrozen voice advances and one result request goes out on the m_ channel.
//   Registers are to be written over the APB port only while the core is idle; the core does not enforce this.
// Sequencing:
//   A plain tick runs S_V_ADV, S_V_LOOK, S_V_SHAPE and S_V_SCALE for each voice
//   and then S_OUT, which publishes the result. A block-start tick first runs
//   S_GLIDE_MUL and S_GLIDE_SUM and then three divisions on the shared
//   restoring divider (dividend width DW = PHASE_BITS + 20). s_tready is high
//   only while the sequencer waits in S_IDLE, so a new tick is not taken
//   until the last one has been published.
// Reset:
//   aresetn (synchronous, active low) loads the register defaults, sets the
//   glide to 110 Hz and clears phases and steps; the steps stay zero until
//   the first block start.
// Stall:
//   The result register holds while m_tready is low; the next tick is still
//   taken and computed, and the sequencer waits only to publish it.
// ----------------------------------------------------------------------------
module ratio_locked_three_voice_oscillator_core
    import rlvo_pkg::*;
#(
    parameter int SAMPLE_RATE     = 44100,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tick channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] block_start, [7:1] zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [14:0] voice_one, [29:15] voice_two,
                                   // [44:30] voice_three, [61:45] mix_out,
                                   // [63:62] zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PB = PHASE_BITS;
    localparam int DW = PB + 20;          // widest dividend: s2 * den_b
    localparam int SW = PB + 31;          // saw product width
    localparam int TB = SINE_TABLE_BITS;

    // ---------------- configuration registers ----------------
    logic [15:0] volume_reg;
    logic [22:0] target_reg;
    logic [7:0]  num_a_reg, den_a_reg, num_b_reg, den_b_reg;
    logic [5:0]  shapes_reg;
    logic [2:0]  freeze_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [7:0]  ratio_wr;

    assign pready   = 1'b1;
    assign cfg_we   = psel & penable & pwrite;
    assign cfg_idx  = paddr[4:2];
    // a zero ratio reads as one
    assign ratio_wr = (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg <= 16'd6554;
            target_reg <= 23'd28160;
            num_a_reg  <= 8'd2;
            den_a_reg  <= 8'd3;
            num_b_reg  <= 8'd2;
            den_b_reg  <= 8'd3;
            shapes_reg <= '0;
            freeze_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_VOLUME:      volume_reg <= pwdata[15:0];
                REG_TARGET_FREQ: target_reg <= pwdata[22:0];
                REG_RATIO_NUM_A: num_a_reg  <= ratio_wr;
                REG_RATIO_DEN_A: den_a_reg  <= ratio_wr;
                REG_RATIO_NUM_B: num_b_reg  <= ratio_wr;
                REG_RATIO_DEN_B: den_b_reg  <= ratio_wr;
                REG_WAVE_SHAPES: shapes_reg <= pwdata[5:0];
                REG_FREEZE_MASK: freeze_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_VOLUME:      prdata = 32'(volume_reg);
            REG_TARGET_FREQ: prdata = 32'(target_reg);
            REG_RATIO_NUM_A: prdata = 32'(num_a_reg);
            REG_RATIO_DEN_A: prdata = 32'(den_a_reg);
            REG_RATIO_NUM_B: prdata = 32'(num_b_reg);
            REG_RATIO_DEN_B: prdata = 32'(den_b_reg);
            REG_WAVE_SHAPES: prdata = 32'(shapes_reg);
            REG_FREEZE_MASK: prdata = 32'(freeze_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- datapath state ----------------
    seq_state_t state_reg, state_next;
    logic [31:0]   glide_reg, glide_next;
    logic [PB-1:0] phase_reg [3];
    logic [PB-1:0] phase_next [3];
    logic [PB-1:0] step_reg [3];
    logic [PB-1:0] step_next [3];
    logic [47:0]   prod_a_reg, prod_a_next;
    logic [41:0]   prod_b_reg, prod_b_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DIV_VW-1:0] dsr_reg, dsr_next;
    logic [DW-1:0] quot_reg, quot_next;
    logic [1:0]    stage_reg, stage_next;
    logic [1:0]    voice_reg, voice_next;
    logic [SW-1:0] saw_reg, saw_next;
    logic          neg_reg, neg_next;
    logic [14:0]   mag_reg, mag_next;
    logic signed [14:0] v_reg [3];
    logic signed [14:0] v_next [3];
    logic signed [16:0] mix_reg, mix_next;
    logic [63:0]   out_reg, out_next;
    logic          mvalid_reg, mvalid_next;

    // divider
    logic          div_start;
    logic          div_done;
    logic [DW-1:0] div_quot;

    rlvo_div #(
        .DW (DW),
        .VW (DIV_VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (dsr_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sine table, addressed by the current voice's phase
    logic [PB-1:0]      cur_phase;
    logic signed [14:0] rom_data;

    assign cur_phase = phase_reg[voice_reg];

    rlvo_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .aclk (aclk),
        .addr (cur_phase[PB-1 -: TB]),
        .data (rom_data)
    );

    // per-voice helpers; a saw at full gain reaches pi/2, and magnitudes keep 15 bits
    logic [1:0]    shape;
    logic [5:0]    shape_sh;
    logic [PB-1:0] half, saw_d;
    logic [SW-1:0] saw_round;
    logic [15:0]   vol_eff;
    logic [30:0]   scl;
    logic [14:0]   scl_mag;
    logic signed [15:0] vsig;

    assign shape_sh  = shapes_reg >> {voice_reg, 1'b0};
    assign shape     = shape_sh[1:0];
    assign half      = PB'(1) << (PB - 1);
    assign saw_d     = cur_phase[PB-1] ? (cur_phase - half) : (half - cur_phase);
    assign saw_round = saw_reg + (SW'(1) << (PB + 15));
    assign vol_eff   = (volume_reg > VOL_MAX) ? VOL_MAX : volume_reg;
    assign scl       = 31'(mag_reg) * 31'(vol_eff) + 31'd16384;
    assign scl_mag   = scl[29:15];
    assign vsig      = neg_reg ? -$signed({1'b0, scl_mag}) : $signed({1'b0, scl_mag});

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next  = state_reg;
        glide_next  = glide_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        dvd_next    = dvd_reg;
        dsr_next    = dsr_reg;
        quot_next   = quot_reg;
        stage_next  = stage_reg;
        voice_next  = voice_reg;
        saw_next    = saw_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        v_next      = v_reg;
        mix_next    = mix_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg;
        div_start   = 1'b0;

        // drop the result once taken
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    stage_next = STAGE_BASE;
                    voice_next = '0;
                    mix_next   = '0;
                    state_next = s_tdata[0] ? S_GLIDE_MUL : S_V_ADV;
                end
            end
            S_GLIDE_MUL: begin
                prod_a_next = 48'(glide_reg) * 48'(GLIDE_KEEP);
                prod_b_next = 42'({target_reg, 8'd0}) * 42'(GLIDE_TAKE);
                state_next  = S_GLIDE_SUM;
            end
            S_GLIDE_SUM: begin
                glide_next = 32'((49'(prod_a_reg) + 49'(prod_b_reg) + 49'd32768) >> 16);
                state_next = S_DIV_PREP;
            end
            S_DIV_PREP: begin
                case (stage_reg)
                    STAGE_BASE: begin
                        dvd_next = DW'(glide_reg) << (PB - 16);
                        dsr_next = DIV_VW'(SAMPLE_RATE);
                    end
                    STAGE_RATIO_A: begin
                        dvd_next = quot_reg * DW'(den_a_reg);
                        dsr_next = DIV_VW'(num_a_reg);
                    end
                    default: begin
                        dvd_next = quot_reg * DW'(den_b_reg);
                        dsr_next = DIV_VW'(num_b_reg);
                    end
                endcase
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    quot_next            = div_quot;
                    step_next[stage_reg] = div_quot[PB-1:0];
                    if (stage_reg == STAGE_RATIO_B) begin
                        state_next = S_V_ADV;
                    end else begin
                        stage_next = stage_reg + 1'b1;
                        state_next = S_DIV_PREP;
                    end
                end
            end
            S_V_ADV: begin
                // hold frozen voices, advance the rest
                if (!freeze_reg[voice_reg]) begin
                    phase_next[voice_reg] = phase_reg[voice_reg] + step_reg[voice_reg];
                end
                state_next = S_V_LOOK;
            end
            S_V_LOOK: begin
                saw_next   = SW'(saw_d) * SW'(PI_Q29);
                state_next = S_V_SHAPE;
            end
            S_V_SHAPE: begin
                case (shape)
                    SHAPE_SQUARE: begin
                        neg_next = !(rom_data > 15'sd0);
                        mag_next = 15'(ONE_Q13);
                    end
                    SHAPE_SAW: begin
                        neg_next = !cur_phase[PB-1];
                        mag_next = saw_round[PB+30:PB+16];
                    end
                    default: begin
                        neg_next = rom_data[14];
                        mag_next = rom_data[14] ? 15'(-rom_data) : 15'(rom_data);
                    end
                endcase
                state_next = S_V_SCALE;
            end
            S_V_SCALE: begin
                v_next[voice_reg] = vsig[14:0];
                mix_next          = mix_reg + 17'(vsig);
                if (voice_reg == LAST_VOICE) begin
                    state_next = S_OUT;
                end else begin
                    voice_next = voice_reg + 1'b1;
                    state_next = S_V_ADV;
                end
            end
            S_OUT: begin
                // wait for the result register to free up
                if (!mvalid_reg || m_tready) begin
                    out_next    = {2'b00, mix_reg, v_reg[2], v_reg[1], v_reg[0]};
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            glide_reg  <= GLIDE_RESET;
            stage_reg  <= '0;
            voice_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                phase_reg[i] <= '0;
                step_reg[i]  <= '0;
            end
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            glide_reg  <= glide_next;
            stage_reg  <= stage_next;
            voice_reg  <= voice_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
        end
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        dvd_reg    <= dvd_next;
        dsr_reg    <= dsr_next;
        quot_reg   <= quot_next;
        saw_reg    <= saw_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        v_reg      <= v_next;
        mix_reg    <= mix_next;
        out_reg    <= out_next;
    end

endmodule
